// File: sv/rrs_pkg.sv
// Shared types and constants for the round-robin slice scheduler.
// No dependencies; every other file in sv/ uses it by scoped names.
`default_nettype none

package rrs_pkg;

    // Fixed field widths of the request, response and config channels
    localparam int unsigned BURST_W   = 16;
    localparam int unsigned QUANTUM_W = 16;
    localparam int unsigned CLOCK_W   = 22;
    localparam int unsigned IDX_OUT_W = 6;

    localparam logic [CLOCK_W-1:0]   CLOCK_MAX     = 22'h3FFFFF;
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

    // Request op codes
    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NOP      = 2'd3
    } rrs_op_t;

    // Response status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } rrs_status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_IDX,
        ST_RUN
    } rrs_state_t;

    // Commands to the ready ring
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
        logic rd;
    } rrs_ring_cmd_t;

    // Commands to the task table
    typedef struct packed {
        logic we;
        logic re;
    } rrs_task_cmd_t;

endpackage

`default_nettype wire

// File: sv/rrs_req_if.sv
// Request channel: valid/ready handshake carrying op and burst_ticks.
// Depends on rrs_pkg for field widths.
`default_nettype none

interface rrs_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic [rrs_pkg::BURST_W-1:0]  burst_ticks;

    modport source (output valid, output op, output burst_ticks, input ready);
    modport sink   (input valid, input op, input burst_ticks, output ready);
endinterface

`default_nettype wire

// File: sv/rrs_rsp_if.sv
// Response channel: valid/ready handshake carrying one slice result.
// Depends on rrs_pkg for field widths.
`default_nettype none

interface rrs_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [rrs_pkg::IDX_OUT_W-1:0]  task_index;
    logic [rrs_pkg::CLOCK_W-1:0]    slice_start;
    logic [rrs_pkg::CLOCK_W-1:0]    slice_stop;
    logic                           task_finished;
    logic [rrs_pkg::CLOCK_W-1:0]    turnaround;
    logic [rrs_pkg::CLOCK_W-1:0]    waiting;
    logic                           all_done;

    modport source (
        output valid, output status, output task_index, output slice_start,
        output slice_stop, output task_finished, output turnaround,
        output waiting, output all_done, input ready
    );
    modport sink (
        input valid, input status, input task_index, input slice_start,
        input slice_stop, input task_finished, input turnaround,
        input waiting, input all_done, output ready
    );
endinterface

`default_nettype wire

// File: sv/round_robin_slice_scheduler_top.sv
// Top level of the round-robin slice scheduler: controller, ready ring and
// task table. Depends on rrs_pkg, rrs_req_if, rrs_rsp_if and the rrs_* modules.
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+--------------------------------------
//  req     | in        | valid/ready      | op, burst_ticks
//  rsp     | out       | valid/ready      | status, task_index, slice_start/stop,
//          |           |                  | task_finished, turnaround, waiting,
//          |           |                  | all_done
//  cfg     | in        | cfg_we           | cfg_wdata -> time_quantum
//
// Load, clear, no-op and failed dispatch are answered from the idle state on acceptance.
// Dispatch passes through ST_IDX and ST_RUN: the two dependent memory reads (ring
// head, then the task entry) followed by the write-back.
// A request is taken when the sequencer is idle and the response register is
// empty or being drained in the same cycle; a stalled rsp holds off req.
// Reset clears pointers, counters and clock; memories need no clearing pass.
`default_nettype none

module round_robin_slice_scheduler_top #(
    parameter int unsigned MAX_TASKS  = 64,
    parameter int unsigned BURST_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rrs_req_if.sink                            req,
    rrs_rsp_if.source                          rsp,
    input  wire logic                          cfg_we,
    input  wire logic [rrs_pkg::QUANTUM_W-1:0] cfg_wdata
);

    // Stored burst width: field width capped by BURST_BITS
    localparam int unsigned BW    = (BURST_BITS < rrs_pkg::BURST_W) ?
                                    BURST_BITS : rrs_pkg::BURST_W;
    localparam int unsigned IDX_W = $clog2(MAX_TASKS);

    rrs_pkg::rrs_ring_cmd_t ring_cmd;
    rrs_pkg::rrs_task_cmd_t task_cmd;
    logic [IDX_W-1:0]       ring_wdata;
    logic [IDX_W-1:0]       ring_rdata;
    logic                   ring_empty;
    logic [IDX_W-1:0]       task_addr;
    logic [BW-1:0]          task_wburst;
    logic [BW-1:0]          task_wrem;
    logic [BW-1:0]          task_rburst;
    logic [BW-1:0]          task_rrem;

    rrs_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .BW        (BW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .ring_cmd    (ring_cmd),
        .ring_wdata  (ring_wdata),
        .ring_rdata  (ring_rdata),
        .ring_empty  (ring_empty),
        .task_cmd    (task_cmd),
        .task_addr   (task_addr),
        .task_wburst (task_wburst),
        .task_wrem   (task_wrem),
        .task_rburst (task_rburst),
        .task_rrem   (task_rrem)
    );

    rrs_ring #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ring_cmd),
        .wdata (ring_wdata),
        .rdata (ring_rdata),
        .empty (ring_empty)
    );

    rrs_task_mem #(
        .MAX_TASKS (MAX_TASKS),
        .BW        (BW)
    ) u_task_mem (
        .clk    (clk),
        .cmd    (task_cmd),
        .addr   (task_addr),
        .wburst (task_wburst),
        .wrem   (task_wrem),
        .rburst (task_rburst),
        .rrem   (task_rrem)
    );

endmodule

`default_nettype wire

// File: sv/rrs_ring.sv
// Ready ring: circular queue of task indices in a synchronous memory,
// with head and count pointers. Depends on rrs_pkg.
`default_nettype none

module rrs_ring #(
    parameter int unsigned MAX_TASKS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rrs_pkg::rrs_ring_cmd_t        cmd,
    input  wire logic [$clog2(MAX_TASKS)-1:0]  wdata,
    output logic      [$clog2(MAX_TASKS)-1:0]  rdata,
    output logic                               empty
);

    localparam int unsigned IDX_W = $clog2(MAX_TASKS);
    localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

    logic [IDX_W-1:0] ring_mem [MAX_TASKS];

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W:0]   tail_sum;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] head_inc;

    // Tail slot = (head + count) mod depth; the sum stays below twice the depth
    always_comb
    begin
        tail_sum = (IDX_W+1)'(head_reg) + (IDX_W+1)'(count_reg);
        if (tail_sum >= (IDX_W+1)'(MAX_TASKS))
        begin
            tail_sum = tail_sum - (IDX_W+1)'(MAX_TASKS);
        end
        tail = tail_sum[IDX_W-1:0];
        head_inc = (head_reg == IDX_W'(MAX_TASKS - 1)) ? '0 : head_reg + 1'b1;
    end

    // Pointer update; a pop and a push in one cycle keep the count
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (cmd.pop)
            begin
                head_next = head_inc;
            end
            if (cmd.push && !cmd.pop)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (cmd.pop && !cmd.push)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Memory: one write at the tail, one registered read at the head
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ring_mem[tail] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata <= ring_mem[head_reg];
        end
    end

    assign empty = (count_reg == '0);

endmodule

`default_nettype wire

// File: sv/rrs_task_mem.sv
// Task table: burst and remaining time of each task, one synchronous memory
// with one write port and one registered read port. Depends on rrs_pkg.
`default_nettype none

module rrs_task_mem #(
    parameter int unsigned MAX_TASKS = 64,
    parameter int unsigned BW        = 16
) (
    input  wire logic                          clk,
    input  wire rrs_pkg::rrs_task_cmd_t        cmd,
    input  wire logic [$clog2(MAX_TASKS)-1:0]  addr,
    input  wire logic [BW-1:0]                 wburst,
    input  wire logic [BW-1:0]                 wrem,
    output logic      [BW-1:0]                 rburst,
    output logic      [BW-1:0]                 rrem
);

    logic [2*BW-1:0] task_mem [MAX_TASKS];
    logic [2*BW-1:0] rd_reg;

    // Entry = {burst, remaining}
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            task_mem[addr] <= {wburst, wrem};
        end
        if (cmd.re)
        begin
            rd_reg <= task_mem[addr];
        end
    end

    assign rburst = rd_reg[2*BW-1:BW];
    assign rrem   = rd_reg[BW-1:0];

endmodule

`default_nettype wire

// File: sv/rrs_ctrl.sv
// Scheduler controller: request decode, dispatch sequencer, clock and task
// counters, quantum register and response register. Depends on rrs_pkg and
// the rrs_req_if / rrs_rsp_if interfaces.
`default_nettype none

module rrs_ctrl #(
    parameter int unsigned MAX_TASKS = 64,
    parameter int unsigned BW        = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    rrs_req_if.sink                                   req,
    rrs_rsp_if.source                                 rsp,
    input  wire logic                                 cfg_we,
    input  wire logic [rrs_pkg::QUANTUM_W-1:0]        cfg_wdata,
    output rrs_pkg::rrs_ring_cmd_t                    ring_cmd,
    output logic      [$clog2(MAX_TASKS)-1:0]         ring_wdata,
    input  wire logic [$clog2(MAX_TASKS)-1:0]         ring_rdata,
    input  wire logic                                 ring_empty,
    output rrs_pkg::rrs_task_cmd_t                    task_cmd,
    output logic      [$clog2(MAX_TASKS)-1:0]         task_addr,
    output logic      [BW-1:0]                        task_wburst,
    output logic      [BW-1:0]                        task_wrem,
    input  wire logic [BW-1:0]                        task_rburst,
    input  wire logic [BW-1:0]                        task_rrem
);

    localparam int unsigned IDX_W = $clog2(MAX_TASKS);
    localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
    localparam int unsigned QW    = rrs_pkg::QUANTUM_W;
    localparam int unsigned CW    = rrs_pkg::CLOCK_W;
    localparam int unsigned OW    = rrs_pkg::IDX_OUT_W;

    rrs_pkg::rrs_state_t state_reg, state_next;

    logic [QW-1:0]    quantum_reg;
    logic [CW-1:0]    clock_reg, clock_next;
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic [CNT_W-1:0] completed_reg, completed_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // Response register
    logic          ovalid_reg, ovalid_next;
    logic [1:0]    status_reg, status_next;
    logic [OW-1:0] index_reg, index_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW-1:0] stop_reg, stop_next;
    logic          fin_reg, fin_next;
    logic [CW-1:0] turn_reg, turn_next;
    logic [CW-1:0] wait_reg, wait_next;
    logic          done_reg, done_next;

    logic             accept;
    logic             emit;
    logic [BW-1:0]    burst_m;
    logic [QW-1:0]    quantum_eff;
    logic [QW-1:0]    rem_w;
    logic [QW-1:0]    run_len;
    logic [QW-1:0]    rem_new;
    logic [CW:0]      stop_sum;
    logic [CW-1:0]    stop_sat;
    logic [CW-1:0]    burst_c;
    logic [IDX_W+OW-1:0] load_idx_ext;
    logic [IDX_W+OW-1:0] run_idx_ext;

    assign req.ready = (state_reg == rrs_pkg::ST_IDLE) && (!ovalid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign burst_m   = req.burst_ticks[BW-1:0];

    // Slice arithmetic on the task read back from the table
    always_comb
    begin
        quantum_eff = (quantum_reg == '0) ? QW'(1) : quantum_reg;
        rem_w       = QW'(task_rrem);
        run_len     = (rem_w < quantum_eff) ? rem_w : quantum_eff;
        rem_new     = rem_w - run_len;
        stop_sum    = (CW+1)'(clock_reg) + (CW+1)'(run_len);
        stop_sat    = stop_sum[CW] ? rrs_pkg::CLOCK_MAX : stop_sum[CW-1:0];
        burst_c     = CW'(task_rburst);
        load_idx_ext = (IDX_W+OW)'(loaded_reg[IDX_W-1:0]);
        run_idx_ext  = (IDX_W+OW)'(idx_reg);
    end

    // Next state, memory commands and response
    always_comb
    begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        loaded_next    = loaded_reg;
        completed_next = completed_reg;
        idx_next       = idx_reg;

        ovalid_next = ovalid_reg && !rsp.ready;
        status_next = status_reg;
        index_next  = index_reg;
        start_next  = start_reg;
        stop_next   = stop_reg;
        fin_next    = fin_reg;
        turn_next   = turn_reg;
        wait_next   = wait_reg;
        done_next   = done_reg;
        emit        = 1'b0;

        ring_cmd    = '0;
        ring_wdata  = loaded_reg[IDX_W-1:0];
        task_cmd    = '0;
        task_addr   = loaded_reg[IDX_W-1:0];
        task_wburst = burst_m;
        task_wrem   = burst_m;

        unique case (state_reg)
            rrs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = rrs_pkg::STAT_OK;
                    index_next  = '0;
                    start_next  = '0;
                    stop_next   = '0;
                    fin_next    = 1'b0;
                    turn_next   = '0;
                    wait_next   = '0;
                    unique case (rrs_pkg::rrs_op_t'(req.op))
                        rrs_pkg::OP_LOAD:
                        begin
                            emit = 1'b1;
                            if (loaded_reg == CNT_W'(MAX_TASKS))
                            begin
                                status_next = rrs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ring_cmd.push = 1'b1;
                                task_cmd.we   = 1'b1;
                                loaded_next   = loaded_reg + 1'b1;
                                index_next    = load_idx_ext[OW-1:0];
                            end
                        end
                        rrs_pkg::OP_DISPATCH:
                        begin
                            if (ring_empty)
                            begin
                                emit        = 1'b1;
                                status_next = rrs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ring_cmd.rd = 1'b1;
                                state_next  = rrs_pkg::ST_IDX;
                            end
                        end
                        rrs_pkg::OP_CLEAR:
                        begin
                            emit           = 1'b1;
                            ring_cmd.clear = 1'b1;
                            loaded_next    = '0;
                            completed_next = '0;
                            clock_next     = '0;
                        end
                        rrs_pkg::OP_NOP:
                        begin
                            emit = 1'b1;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            // Head index is out of the ring; fetch its task entry
            rrs_pkg::ST_IDX:
            begin
                task_cmd.re = 1'b1;
                task_addr   = ring_rdata;
                idx_next    = ring_rdata;
                state_next  = rrs_pkg::ST_RUN;
            end

            // Run the slice, write back, requeue or retire
            rrs_pkg::ST_RUN:
            begin
                emit         = 1'b1;
                task_cmd.we  = 1'b1;
                task_addr    = idx_reg;
                task_wburst  = task_rburst;
                task_wrem    = rem_new[BW-1:0];
                ring_cmd.pop = 1'b1;
                ring_wdata   = idx_reg;
                clock_next   = stop_sat;

                status_next = rrs_pkg::STAT_OK;
                index_next  = run_idx_ext[OW-1:0];
                start_next  = clock_reg;
                stop_next   = stop_sat;
                if (rem_new != '0)
                begin
                    ring_cmd.push = 1'b1;
                    fin_next      = 1'b0;
                    turn_next     = '0;
                    wait_next     = '0;
                end
                else
                begin
                    completed_next = completed_reg + 1'b1;
                    fin_next       = 1'b1;
                    turn_next      = stop_sat;
                    wait_next      = (stop_sat > burst_c) ? stop_sat - burst_c : '0;
                end
                state_next = rrs_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = rrs_pkg::ST_IDLE;
            end
        endcase

        if (emit)
        begin
            ovalid_next = 1'b1;
            done_next   = (completed_next == loaded_next);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrs_pkg::ST_IDLE;
            quantum_reg   <= rrs_pkg::QUANTUM_RESET;
            clock_reg     <= '0;
            loaded_reg    <= '0;
            completed_reg <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            loaded_reg    <= loaded_next;
            completed_reg <= completed_next;
            ovalid_reg    <= ovalid_next;
            if (cfg_we)
            begin
                quantum_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        start_reg  <= start_next;
        stop_reg   <= stop_next;
        fin_reg    <= fin_next;
        turn_reg   <= turn_next;
        wait_reg   <= wait_next;
        done_reg   <= done_next;
    end

    assign rsp.valid         = ovalid_reg;
    assign rsp.status        = status_reg;
    assign rsp.task_index    = index_reg;
    assign rsp.slice_start   = start_reg;
    assign rsp.slice_stop    = stop_reg;
    assign rsp.task_finished = fin_reg;
    assign rsp.turnaround    = turn_reg;
    assign rsp.waiting       = wait_reg;
    assign rsp.all_done      = done_reg;

endmodule

`default_nettype wire

// File: tb/rrs_slice_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the round-robin slice scheduler: tracks quantum writes, predicts one result
// per accepted request and compares each accepted response. Depends on rrs_pkg and the channel interfaces.
module rrs_slice_checker
    import rrs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    rrs_req_if                   req,
    rrs_rsp_if                   rsp,
    input  logic                 cfg_we,
    input  logic [QUANTUM_W-1:0] cfg_wdata,
    output int                   mismatches,
    output int                   pending
);

    localparam int unsigned TASK_SLOTS = 64;

    typedef struct packed {
        rrs_status_t           status;
        logic [IDX_OUT_W-1:0]  task_index;
        logic [CLOCK_W-1:0]    slice_start;
        logic [CLOCK_W-1:0]    slice_stop;
        logic                  task_finished;
        logic [CLOCK_W-1:0]    turnaround;
        logic [CLOCK_W-1:0]    waiting;
        logic                  all_done;
    } slice_result_t;

    // Shadow scheduler state
    logic [BURST_W-1:0]   task_burst [TASK_SLOTS];
    logic [BURST_W-1:0]   task_left  [TASK_SLOTS];
    logic [5:0]           ready_order [TASK_SLOTS];
    logic [5:0]           order_head;
    logic [6:0]           order_count;
    logic [6:0]           n_loaded;
    logic [6:0]           n_completed;
    logic [CLOCK_W-1:0]   now_ticks;
    logic [QUANTUM_W-1:0] quantum;

    slice_result_t expected_slices [$];

    function automatic void clear_schedule();
        order_head  = '0;
        order_count = '0;
        n_loaded    = '0;
        n_completed = '0;
        now_ticks   = '0;
    endfunction

    // Applies one request to the shadow state and returns the slice it should report
    function automatic slice_result_t predict_slice(input rrs_op_t op,
                                                    input logic [BURST_W-1:0] burst);
        slice_result_t        r;
        logic [5:0]           idx;
        logic [5:0]           tail;
        logic [QUANTUM_W-1:0] q;
        logic [BURST_W-1:0]   left;
        logic [BURST_W-1:0]   run;
        logic [CLOCK_W:0]     stop_wide;
        logic [CLOCK_W-1:0]   stop;
        r = '0;
        case (op)
            OP_LOAD: begin
                if (n_loaded >= TASK_SLOTS) begin
                    r.status = STAT_FULL;
                end else begin
                    idx = n_loaded[5:0];
                    task_burst[idx] = burst;
                    task_left[idx]  = burst;
                    tail = order_head + order_count[5:0];
                    ready_order[tail] = idx;
                    order_count++;
                    n_loaded++;
                    r.task_index = idx;
                end
            end
            OP_DISPATCH: begin
                if (order_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    idx  = ready_order[order_head];
                    q    = (quantum == 0) ? QUANTUM_W'(1) : quantum;
                    left = task_left[idx];
                    run  = (left < q) ? left : q;
                    stop_wide = {1'b0, now_ticks} + (CLOCK_W + 1)'(run);
                    stop = (stop_wide > {1'b0, CLOCK_MAX}) ? CLOCK_MAX : stop_wide[CLOCK_W-1:0];
                    r.task_index  = idx;
                    r.slice_start = now_ticks;
                    r.slice_stop  = stop;
                    order_head++;
                    order_count--;
                    left = left - run;
                    task_left[idx] = left;
                    now_ticks = stop;
                    if (left != 0) begin
                        // unfinished: back to the tail of the ring
                        tail = order_head + order_count[5:0];
                        ready_order[tail] = idx;
                        order_count++;
                    end else begin
                        r.task_finished = 1'b1;
                        r.turnaround    = stop;
                        r.waiting = (stop > CLOCK_W'(task_burst[idx]))
                                    ? stop - CLOCK_W'(task_burst[idx]) : '0;
                        n_completed++;
                    end
                end
            end
            OP_CLEAR: clear_schedule();
            default: ;
        endcase
        r.all_done = (n_completed == n_loaded);
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [CLOCK_W-1:0] want,
                                          input logic [CLOCK_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Track config, check responses, then queue predictions for new requests
    always @(posedge clk or negedge rst_n) begin : monitor
        slice_result_t want;
        if (!rst_n) begin
            clear_schedule();
            quantum = QUANTUM_RESET;
            expected_slices.delete();
            mismatches = 0;
            pending = 0;
        end else begin
            if (cfg_we)
                quantum = cfg_wdata;
            if (rsp.valid && rsp.ready) begin
                if (expected_slices.size() == 0) begin
                    $error("response transaction with no request pending");
                    mismatches++;
                end else begin
                    want = expected_slices.pop_front();
                    compare_field("status", CLOCK_W'(want.status), CLOCK_W'(rsp.status));
                    compare_field("task_index", CLOCK_W'(want.task_index),
                                  CLOCK_W'(rsp.task_index));
                    compare_field("slice_start", want.slice_start, rsp.slice_start);
                    compare_field("slice_stop", want.slice_stop, rsp.slice_stop);
                    compare_field("task_finished", CLOCK_W'(want.task_finished),
                                  CLOCK_W'(rsp.task_finished));
                    compare_field("turnaround", want.turnaround, rsp.turnaround);
                    compare_field("waiting", want.waiting, rsp.waiting);
                    compare_field("all_done", CLOCK_W'(want.all_done), CLOCK_W'(rsp.all_done));
                end
            end
            if (req.valid && req.ready)
                expected_slices.push_back(predict_slice(rrs_op_t'(req.op), req.burst_ticks));
            pending = expected_slices.size();
        end
    end

endmodule

// File: tb/round_robin_slice_scheduler_top_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the round-robin slice scheduler: directed items, then phases
// of load/dispatch traffic under random quanta.
// Depends on rrs_pkg, the channel interfaces and rrs_slice_checker.
module round_robin_slice_scheduler_top_tb;
    import rrs_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned DIRECTED_MAX = 25;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PRESSURE_AT  = 150;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned TASK_SLOTS   = 64;

    typedef enum int unsigned {
        PH_BATCH,
        PH_FILL,
        PH_MIXED,
        PH_NOISE
    } phase_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [QUANTUM_W-1:0] cfg_wdata;
    int                   mismatches;
    int                   pending;
    int unsigned          items_sent;
    int unsigned          req_accepted = 0;
    int unsigned          idle_cycles = 0;
    int unsigned          run_left;
    logic [QUANTUM_W-1:0] cur_quantum;

    rrs_req_if req ();
    rrs_rsp_if rsp ();

    round_robin_slice_scheduler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    rrs_slice_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (req.valid && req.ready)
            req_accepted <= req_accepted + 1;
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Drive one request and hold it until taken; sender runs in bursts with gaps
    task automatic send_item(input rrs_op_t op, input logic [BURST_W-1:0] burst);
        int unsigned gap;
        req.valid       <= 1'b1;
        req.op          <= op;
        req.burst_ticks <= burst;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
        if (run_left > 1)
            run_left--;
        else
        begin
            run_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Drain everything, let a dispatch in flight retire, then write the quantum
    task automatic write_quantum(input logic [QUANTUM_W-1:0] value);
        req.valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_quantum = value;
    endtask

    // First phases walk the extremes, then mostly small quanta
    function automatic logic [QUANTUM_W-1:0] pick_quantum(input int unsigned phase_no);
        case (phase_no)
            0: return '0;          // zero acts as one tick
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'd2;
            4: return 16'($urandom_range(1, 65535));
            5: return 16'd4;
            default:
                case ($urandom_range(0, 5))
                    0: return 16'($urandom_range(0, 65535));
                    1: return 16'hFFFF;
                    2: return '0;
                    default: return 16'($urandom_range(1, 8));
                endcase
        endcase
    endfunction

    // Bursts stay within a few slices; large ones only when the quantum is large
    function automatic logic [BURST_W-1:0] pick_burst(input int unsigned q);
        int unsigned roll;
        int unsigned hi;
        roll = $urandom_range(0, 9);
        hi = (3 * q < 12) ? 3 * q : 12;
        if (roll == 0)
            return '0;
        if (roll == 1 && q >= 16384)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(1, hi));
    endfunction

    function automatic int unsigned slices_for(input int unsigned burst, input int unsigned q);
        return (burst == 0) ? 1 : (burst + q - 1) / q;
    endfunction

    // Receiver: stall patterns of random span, with one long hold-off under load
    initial
    begin : receiver
        int unsigned mode;
        int unsigned span;
        bit          held;
        rsp.ready = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && req_accepted >= PRESSURE_AT)
            begin
                held = 1'b1;
                @(negedge clk);
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 60);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= 1'($urandom_range(0, 1));
                    default: rsp.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int unsigned phase_no;
        int unsigned q_eff;
        int unsigned need;
        int unsigned roll;
        logic [BURST_W-1:0] b;
        phase_kind_t kind;
        req.valid       = 1'b0;
        req.op          = OP_NOP;
        req.burst_ticks = '0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        rst_n           = 1'b0;
        items_sent      = 0;
        run_left        = 1;
        cur_quantum     = QUANTUM_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty ring, zero and max bursts, requeue, clear, ignored burst field
        send_item(OP_DISPATCH, '0);
        send_item(OP_NOP, 16'hFFFF);
        send_item(OP_LOAD, 16'd0);
        send_item(OP_LOAD, 16'hFFFF);
        send_item(OP_LOAD, 16'd1);
        send_item(OP_LOAD, 16'd6);
        repeat (6) send_item(OP_DISPATCH, '0);
        send_item(OP_LOAD, 16'h5555);
        send_item(OP_DISPATCH, 16'hFFFF);
        send_item(OP_DISPATCH, '0);
        send_item(OP_CLEAR, '0);
        send_item(OP_DISPATCH, '0);
        send_item(OP_NOP, '0);
        send_item(OP_LOAD, 16'hAAAA);
        send_item(OP_CLEAR, 16'hFFFF);

        // Random phases
        phase_no = 0;
        while (items_sent < DIRECTED_MAX + RANDOM_ITEMS)
        begin
            if (phase_no < 6 || $urandom_range(0, 1) == 0)
                write_quantum(pick_quantum(phase_no));
            q_eff = (cur_quantum == 0) ? 1 : cur_quantum;
            if (phase_no == 2 || phase_no == 7)
                kind = PH_FILL;
            else
            begin
                roll = $urandom_range(0, 9);
                kind = (roll < 6) ? PH_BATCH : (roll == 6) ? PH_FILL :
                       (roll < 9) ? PH_MIXED : PH_NOISE;
            end
            case (kind)
                PH_BATCH:
                begin
                    // load a handful of tasks, then run the ring dry
                    send_item(OP_CLEAR, 16'($urandom_range(0, 65535)));
                    need = $urandom_range(0, 2);
                    repeat ($urandom_range(1, 16))
                    begin
                        b = pick_burst(q_eff);
                        need += slices_for(b, q_eff);
                        send_item(OP_LOAD, b);
                    end
                    repeat (need)
                    begin
                        if ($urandom_range(0, 19) == 0)
                            send_item(OP_NOP, 16'($urandom_range(0, 65535)));
                        send_item(OP_DISPATCH, 16'($urandom_range(0, 65535)));
                    end
                end
                PH_FILL:
                begin
                    // fill the table, overflow it, then drain across ring wrap
                    send_item(OP_CLEAR, '0);
                    need = 1;
                    repeat (TASK_SLOTS)
                    begin
                        b = 16'($urandom_range(0, 2));
                        need += slices_for(b, q_eff);
                        send_item(OP_LOAD, b);
                    end
                    repeat ($urandom_range(1, 3))
                        send_item(OP_LOAD, 16'($urandom_range(0, 65535)));
                    repeat (need)
                        send_item(OP_DISPATCH, '0);
                end
                PH_MIXED:
                begin
                    repeat (40)
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll < 35)
                            send_item(OP_LOAD, pick_burst(q_eff));
                        else if (roll < 90)
                            send_item(OP_DISPATCH, '0);
                        else if (roll < 97)
                            send_item(OP_NOP, 16'($urandom_range(0, 65535)));
                        else
                            send_item(OP_CLEAR, '0);
                    end
                end
                default:
                begin
                    repeat (20)
                        send_item(rrs_op_t'($urandom_range(0, 3)),
                                  16'($urandom_range(0, 65535)));
                end
            endcase
            phase_no++;
        end

        // Drain and give the verdict
        req.valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
